FILE: rtl/core/psgc_pkg.sv
// ----------------------------------------------------------------------------
// psgc_pkg - shared types and constants for the polygon geometry comparator
// Holds coordinate widths, the vertex record, command codes and the default
// polygon capacity.
// ----------------------------------------------------------------------------
package psgc_pkg;

  localparam int COORD_W       = 32;
  localparam int EPS_W         = 31;
  localparam int CMD_W         = 2;
  localparam int MAX_VERTS_DEF = 64;

  // command codes; the fourth code is ignored
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPARE = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  localparam int VERT_W = $bits(vertex_t);

endpackage

FILE: rtl/core/psgc_if.sv
// ----------------------------------------------------------------------------
// psgc_if - valid/ready channels of the polygon geometry comparator
// psgc_in_if carries command words with one vertex, psgc_out_if carries
// compare results.
// ----------------------------------------------------------------------------
interface psgc_in_if
  import psgc_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, command, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, command, coord_x, coord_y, coord_z, output ready);
endinterface

interface psgc_out_if;
  logic valid;
  logic ready;
  logic same_geometry;
  logic status;

  modport source (output valid, same_geometry, status, input ready);
  modport sink   (input valid, same_geometry, status, output ready);
endinterface

FILE: rtl/core/polygon_same_geometry_compare.sv
// ----------------------------------------------------------------------------
// polygon_same_geometry_compare - cyclic polygon equality check
// Loads two polygons vertex by vertex and on compare reports whether they
// hold the same cyclic vertex sequence, forward or reversed.
//
//   channel  dir  handshake        word
//   in_ch    in   valid/ready      command, coord_x, coord_y, coord_z
//   out_ch   out  valid/ready      same_geometry, status
//   cfg      in   cfg_we           cfg_wdata = epsilon
//
// A compare holds in_ch.ready low while it scans B for the start vertex,
// walks forward, walks in reverse if the forward walk fails, and finishes;
// unequal or empty polygons go straight to the finish step.
// The finish step stalls while the previous result word is not taken.
// Reset is synchronous, active low; vertex stores are not cleared.
// ----------------------------------------------------------------------------
module polygon_same_geometry_compare
  import psgc_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  psgc_in_if.sink          in_ch,
  psgc_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [EPS_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_FWD  = 5'b00100,
    ST_REV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]    cnt_b_r, cnt_b_nxt;
  logic             ovf_r, ovf_nxt;
  logic [EPS_W-1:0] eps_r;
  logic [AW-1:0]    addr_a_r, addr_a_nxt;
  logic [AW-1:0]    addr_b_r, addr_b_nxt;
  logic [AW-1:0]    bd_r, bd_nxt;
  logic [AW-1:0]    m_r, m_nxt;
  logic [CW-1:0]    chk_r, chk_nxt;
  logic             dv_r, dv_nxt;
  logic             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_same_r, out_same_nxt;
  logic             out_status_r, out_status_nxt;

  logic             in_acc;
  logic             full_a;
  logic             full_b;
  logic             we_a;
  logic             we_b;
  logic [CW-1:0]    cnt_m1;
  logic [AW-1:0]    last_idx;
  logic [AW-1:0]    m_inc;
  logic [VERT_W-1:0] rdata_a;
  logic [VERT_W-1:0] rdata_b;
  vertex_t          wvert;
  logic             match;

  function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] v,
                                             input logic [AW-1:0] last);
    return (v == last) ? '0 : v + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] v,
                                             input logic [AW-1:0] last);
    return (v == '0) ? last : v - AW'(1);
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full_a      = (cnt_a_r == CW'(MAX_VERTS));
  assign full_b      = (cnt_b_r == CW'(MAX_VERTS));
  assign we_a        = in_acc && (in_ch.command == CMD_LOAD_A) && !full_a;
  assign we_b        = in_acc && (in_ch.command == CMD_LOAD_B) && !full_b;
  assign cnt_m1      = cnt_a_r - CW'(1);
  assign last_idx    = cnt_m1[AW-1:0];
  assign m_inc       = inc_wrap(m_r, last_idx);

  assign wvert.x = in_ch.coord_x;
  assign wvert.y = in_ch.coord_y;
  assign wvert.z = in_ch.coord_z;

  // vertex stores
  psgc_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[AW-1:0]),
    .wdata (wvert),
    .raddr (addr_a_r),
    .rdata (rdata_a)
  );

  psgc_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[AW-1:0]),
    .wdata (wvert),
    .raddr (addr_b_r),
    .rdata (rdata_b)
  );

  // shared vertex compare unit
  psgc_vmatch u_vmatch (
    .vert_a  (vertex_t'(rdata_a)),
    .vert_b  (vertex_t'(rdata_b)),
    .epsilon (eps_r),
    .match   (match)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    ovf_nxt        = ovf_r;
    addr_a_nxt     = addr_a_r;
    addr_b_nxt     = addr_b_r;
    bd_nxt         = addr_b_r;
    m_nxt          = m_r;
    chk_nxt        = chk_r;
    dv_nxt         = 1'b1;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_same_nxt   = out_same_r;
    out_status_nxt = out_status_r;

    // drop the result word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        dv_nxt = 1'b0;
        if (in_acc) begin
          unique case (in_ch.command)
            CMD_LOAD_A: begin
              if (full_a) ovf_nxt = 1'b1;
              else cnt_a_nxt = cnt_a_r + CW'(1);
            end
            CMD_LOAD_B: begin
              if (full_b) ovf_nxt = 1'b1;
              else cnt_b_nxt = cnt_b_r + CW'(1);
            end
            CMD_COMPARE: begin
              if ((cnt_a_r != cnt_b_r) || (cnt_a_r == '0)) begin
                res_nxt   = 1'b0;
                state_nxt = ST_FIN;
              end else begin
                addr_a_nxt = '0;
                addr_b_nxt = '0;
                chk_nxt    = cnt_a_r;
                state_nxt  = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // hold A at vertex 0, walk B
        addr_b_nxt = inc_wrap(addr_b_r, last_idx);
        if (dv_r) begin
          if (match) begin
            m_nxt = bd_r;
            if (cnt_a_r == CW'(1)) begin
              res_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              addr_a_nxt = AW'(1);
              addr_b_nxt = inc_wrap(bd_r, last_idx);
              chk_nxt    = cnt_m1;
              dv_nxt     = 1'b0;
              state_nxt  = ST_FWD;
            end
          end else if (chk_r == CW'(1)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            chk_nxt = chk_r - CW'(1);
          end
        end
      end

      ST_FWD: begin
        // advance A and B together
        addr_a_nxt = inc_wrap(addr_a_r, last_idx);
        addr_b_nxt = inc_wrap(addr_b_r, last_idx);
        if (dv_r) begin
          if (!match) begin
            addr_a_nxt = last_idx;
            addr_b_nxt = m_inc;
            chk_nxt    = cnt_a_r;
            dv_nxt     = 1'b0;
            state_nxt  = ST_REV;
          end else if (chk_r == CW'(1)) begin
            res_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            chk_nxt = chk_r - CW'(1);
          end
        end
      end

      ST_REV: begin
        // walk A backward against B forward
        addr_a_nxt = dec_wrap(addr_a_r, last_idx);
        addr_b_nxt = inc_wrap(addr_b_r, last_idx);
        if (dv_r) begin
          if (!match) begin
            res_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end else if (chk_r == CW'(1)) begin
            res_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            chk_nxt = chk_r - CW'(1);
          end
        end
      end

      ST_FIN: begin
        // hold until the output register is free, then clear the polygons
        dv_nxt = 1'b0;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_same_nxt   = res_r;
          out_status_nxt = ovf_r;
          cnt_a_nxt      = '0;
          cnt_b_nxt      = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      eps_r       <= EPS_W'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ovf_r       <= ovf_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    addr_a_r     <= addr_a_nxt;
    addr_b_r     <= addr_b_nxt;
    bd_r         <= bd_nxt;
    m_r          <= m_nxt;
    chk_r        <= chk_nxt;
    res_r        <= res_nxt;
    out_same_r   <= out_same_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.same_geometry = out_same_r;
  assign out_ch.status        = out_status_r;

`ifndef ASSERT_OFF
  // a walk only runs on equal, nonempty polygons
  a_walk_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_FWD || state_r == ST_REV) |->
      (cnt_a_r == cnt_b_r && cnt_a_r != '0))
    else $error("compare walk with unequal or empty polygons");

  // a new result word leaves both polygons and the overflow flag cleared
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r))
    else $error("result issued without clearing polygon state");

  // a result word only comes out of the finish step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result word raised outside finish step");
`endif

endmodule

FILE: rtl/core/psgc_ram.sv
// ----------------------------------------------------------------------------
// psgc_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module psgc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write when enabled, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/psgc_vmatch.sv
// ----------------------------------------------------------------------------
// psgc_vmatch - vertex tolerance compare unit
// Flags a match when every coordinate pair differs by strictly less than
// epsilon. Differences are taken at 33 bits so they never wrap.
// ----------------------------------------------------------------------------
module psgc_vmatch
  import psgc_pkg::*;
(
  input  vertex_t          vert_a,
  input  vertex_t          vert_b,
  input  logic [EPS_W-1:0] epsilon,
  output logic             match
);

  // -eps < a - b < eps, both bounds checked in parallel on the difference
  function automatic logic coord_ok(input logic signed [COORD_W-1:0] a,
                                    input logic signed [COORD_W-1:0] b,
                                    input logic [EPS_W-1:0] eps);
    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] pos_eps;
    logic signed [COORD_W:0] neg_eps;
    diff    = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    pos_eps = $signed({2'b00, eps});
    neg_eps = -pos_eps;
    return (diff < pos_eps) && (diff > neg_eps);
  endfunction

  assign match = coord_ok(vert_a.x, vert_b.x, epsilon) &&
                 coord_ok(vert_a.y, vert_b.y, epsilon) &&
                 coord_ok(vert_a.z, vert_b.z, epsilon);

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - self-checking bench for polygon_same_geometry_compare
// Loads polygon pairs through the command channel and predicts each compare
// result with a behavioral model of the rotation and reversal match. It
// starts with a short directed table, then runs random polygon pairs under
// several tolerance settings. Both channels idle at random, and the bench
// includes a long output hold-off and a calm stretch with no idling.
// ----------------------------------------------------------------------------
module testbench;
  import psgc_pkg::*;

  localparam int               MAX_VERTS       = MAX_VERTS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;
  localparam int               HOLD_OFF_CYCLES = 400;
  localparam int               SETTLE_CYCLES   = 8;
  localparam int               DRAIN_CYCLES    = 250;
  localparam int               PHASE_ITEMS     = 210;
  localparam int               N_PHASES        = 6;
  localparam longint           COORD_MAX       = 64'sd2147483647;
  localparam longint           COORD_MIN       = -64'sd2147483648;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic same;
    logic status;
  } verdict_t;

  typedef struct {
    row_kind_t           kind;
    logic [CMD_W-1:0]    cmd;
    logic signed [31:0]  x;
    logic signed [31:0]  y;
    logic signed [31:0]  z;
    logic [EPS_W-1:0]    eps;
    bit                  fixed;
    bit                  fix_same;
    bit                  fix_status;
  } stim_row_t;

  // directed words; a set fixed flag carries a result typed in by hand
  stim_row_t dir_table [28] = '{
    '{ROW_WORD, CMD_COMPARE, 0, 0, 0, 0, 1, 0, 0},
    '{ROW_WORD, CMD_UNUSED, -1, -1, -1, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_A, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_COMPARE, -1, -1, -1, 0, 1, 1, 0},
    '{ROW_WORD, CMD_LOAD_A, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0},
    '{ROW_WORD, CMD_COMPARE, 0, 0, 0, 0, 1, 0, 0},
    '{ROW_WORD, CMD_LOAD_A, 1, 2, 3, 0, 0, 0, 0},
    '{ROW_WORD, CMD_COMPARE, 0, 0, 0, 0, 1, 0, 0},
    '{ROW_CFG, CMD_COMPARE, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_A, 5, 5, 5, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 5, 5, 5, 0, 0, 0, 0},
    '{ROW_WORD, CMD_COMPARE, 0, 0, 0, 0, 1, 0, 0},
    '{ROW_CFG, CMD_COMPARE, 0, 0, 0, 31'h7FFFFFFF, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_A, 32'sh7FFFFFFF, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 1, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_COMPARE, 0, 0, 0, 0, 1, 1, 0},
    '{ROW_WORD, CMD_LOAD_A, 32'sh7FFFFFFF, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 32'sh80000000, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_COMPARE, 0, 0, 0, 0, 1, 0, 0},
    '{ROW_CFG, CMD_COMPARE, 0, 0, 0, 3, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_A, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_A, 10, 0, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_A, 0, 10, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 0, 12, 0, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 10, 0, -2, 0, 0, 0, 0},
    '{ROW_WORD, CMD_LOAD_B, 0, 0, 2, 0, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [EPS_W-1:0] cfg_wdata;

  psgc_in_if  in_ch ();
  psgc_out_if out_ch ();

  polygon_same_geometry_compare dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow state of the comparator
  vertex_t  poly_a [MAX_VERTS];
  vertex_t  poly_b [MAX_VERTS];
  int       cnt_a;
  int       cnt_b;
  bit       ovf_seen;
  longint   eps_model;
  verdict_t verdict_q [$];

  int mismatch_count;
  int items_sent;
  bit calm_mode;
  bit rx_hold_req;
  int rx_hold_left;

  always #5 clk = ~clk;

  // abort a hung run
  initial begin
    #4000000;
    $display("polygon_same_geometry_compare verification failed");
    $finish;
  end

  function automatic bit coord_close(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d < eps_model;
  endfunction

  function automatic bit verts_match(vertex_t p, vertex_t q);
    return coord_close(p.x, q.x) && coord_close(p.y, q.y) && coord_close(p.z, q.z);
  endfunction

  // cyclic match of A against B, forward first, then reversed
  function automatic bit polygons_same();
    int n, m, k;
    bit fwd_ok;
    n = cnt_a;
    if (n != cnt_b || n == 0) return 1'b0;
    for (m = 0; m < n; m++)
      if (verts_match(poly_a[0], poly_b[m])) break;
    if (m == n) return 1'b0;
    fwd_ok = 1'b1;
    for (k = 1; k < n; k++) begin
      if (!verts_match(poly_a[k], poly_b[(m + k) % n])) begin
        fwd_ok = 1'b0;
        break;
      end
    end
    if (fwd_ok) return 1'b1;
    for (k = 0; k < n; k++)
      if (!verts_match(poly_a[n - 1 - k], poly_b[(m + 1 + k) % n])) return 1'b0;
    return 1'b1;
  endfunction

  // advance the shadow state by one accepted word
  function automatic void absorb_word(logic [CMD_W-1:0] cmd, vertex_t v, bit fixed,
                                      verdict_t fix);
    verdict_t res;
    case (cmd)
      CMD_LOAD_A: begin
        if (cnt_a < MAX_VERTS) begin
          poly_a[cnt_a] = v;
          cnt_a++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CMD_LOAD_B: begin
        if (cnt_b < MAX_VERTS) begin
          poly_b[cnt_b] = v;
          cnt_b++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      CMD_COMPARE: begin
        res.same   = polygons_same();
        res.status = ovf_seen;
        verdict_q.push_back(fixed ? fix : res);
        cnt_a    = 0;
        cnt_b    = 0;
        ovf_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return $signed($urandom_range(0, 64)) - 32'sd32;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    v.x = rand_coord();
    v.y = rand_coord();
    v.z = rand_coord();
    return v;
  endfunction

  // move a coordinate by mag in a random direction, saturated
  function automatic logic signed [31:0] nudge(logic signed [31:0] c, longint mag);
    longint t;
    t = $urandom_range(0, 1) ? longint'(c) + mag : longint'(c) - mag;
    if (t > COORD_MAX) t = COORD_MAX;
    if (t < COORD_MIN) t = COORD_MIN;
    return t[31:0];
  endfunction

  // pick a shift that stays inside the tolerance
  function automatic longint jitter_mag();
    if (eps_model == 0) return 0;
    if ($urandom_range(0, 3) == 0) return eps_model - 1;
    return $urandom_range(0, 32'(eps_model - 1));
  endfunction

  // offer one word, hold it until accepted, then predict
  task automatic send_word(logic [CMD_W-1:0] cmd, vertex_t v, bit fixed, verdict_t fix);
    if (!calm_mode && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.coord_x <= v.x;
    in_ch.coord_y <= v.y;
    in_ch.coord_z <= v.z;
    do @(posedge clk); while (!in_ch.ready);
    absorb_word(cmd, v, fixed, fix);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // drain the block, then write the tolerance
  task automatic set_epsilon(logic [EPS_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eps_model = val;
  endtask

  // one polygon pair: build A, derive B, interleave the loads, compare
  task automatic run_polygon_case();
    vertex_t va [$];
    vertex_t vb [$];
    vertex_t v;
    int n, r, style, shift, idx, ia, ib, j;
    bit pick_a;
    r = $urandom_range(0, 99);
    if (r < 72)      n = $urandom_range(1, 6);
    else if (r < 94) n = $urandom_range(7, 16);
    else if (r < 97) n = $urandom_range(60, 64);
    else             n = $urandom_range(65, 67);
    style = $urandom_range(0, 5);
    for (j = 0; j < n; j++) begin
      if (style == 5) begin
        // few distinct values so that B holds repeats of A's first vertex
        v.x = $signed($urandom_range(0, 2)) - 32'sd1;
        v.y = $signed($urandom_range(0, 2)) - 32'sd1;
        v.z = $signed($urandom_range(0, 1));
        va.push_back(v);
      end else begin
        va.push_back(rand_vertex());
      end
    end
    shift = $urandom_range(0, n - 1);
    for (j = 0; j < n; j++) begin
      if (style == 1 || (style == 5 && shift[0]))
        idx = (shift + n - j) % n;
      else
        idx = (j + shift) % n;
      v = (style == 4) ? rand_vertex() : va[idx];
      if (style != 5) begin
        v.x = nudge(v.x, jitter_mag());
        v.y = nudge(v.y, jitter_mag());
        v.z = nudge(v.z, jitter_mag());
      end
      vb.push_back(v);
    end
    // break one vertex just past the tolerance
    if (style == 2) begin
      idx = $urandom_range(0, n - 1);
      case ($urandom_range(0, 2))
        0:       vb[idx].x = nudge(va[(idx + shift) % n].x, eps_model + $urandom_range(0, 3));
        1:       vb[idx].y = nudge(va[(idx + shift) % n].y, eps_model + $urandom_range(0, 3));
        default: vb[idx].z = nudge(va[(idx + shift) % n].z, eps_model + $urandom_range(0, 3));
      endcase
    end
    if (style == 3) begin
      if ($urandom_range(0, 1)) void'(vb.pop_back());
      else vb.push_back(rand_vertex());
    end
    ia = 0;
    ib = 0;
    while (ia < va.size() || ib < vb.size()) begin
      if ($urandom_range(0, 99) < 4)
        send_word(CMD_UNUSED, rand_vertex(), 1'b0, '0);
      pick_a = (ib >= vb.size()) || (ia < va.size() && $urandom_range(0, 1));
      if (pick_a) begin
        send_word(CMD_LOAD_A, va[ia], 1'b0, '0);
        ia++;
      end else begin
        send_word(CMD_LOAD_B, vb[ib], 1'b0, '0);
        ib++;
      end
    end
    // a missing compare carries the loads into the next pair
    if ($urandom_range(0, 99) < 95)
      send_word(CMD_COMPARE, rand_vertex(), 1'b0, '0);
    if ($urandom_range(0, 99) < 4)
      send_word(CMD_COMPARE, rand_vertex(), 1'b0, '0);
  endtask

  // result sink: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req && rx_hold_left == 0) begin
      rx_hold_left = HOLD_OFF_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (calm_mode) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result word same_geometry=%0b status=%0b", $time,
                 out_ch.same_geometry, out_ch.status);
        mismatch_count++;
      end else begin
        want = verdict_q.pop_front();
        if (out_ch.same_geometry !== want.same) begin
          $display("%0t: same_geometry expected %0b actual %0b", $time, want.same,
                   out_ch.same_geometry);
          mismatch_count++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status,
                   out_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    vertex_t v;
    logic [EPS_W-1:0] eps_plan [N_PHASES];
    int phase, phase_end;
    bit hold_done;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_LOAD_A;
    in_ch.coord_x  = '0;
    in_ch.coord_y  = '0;
    in_ch.coord_z  = '0;
    out_ch.ready   = 1'b0;
    cnt_a          = 0;
    cnt_b          = 0;
    ovf_seen       = 1'b0;
    eps_model      = 1;
    mismatch_count = 0;
    items_sent     = 0;
    calm_mode      = 1'b0;
    rx_hold_req    = 1'b0;
    rx_hold_left   = 0;
    hold_done      = 1'b0;
    eps_plan = '{31'd16, 31'd0, 31'h7FFFFFFF, 31'd65536, 31'($urandom_range(2, 1 << 20)),
                 31'd1};

    // hold reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        set_epsilon(dir_table[i].eps);
      end else begin
        v.x = dir_table[i].x;
        v.y = dir_table[i].y;
        v.z = dir_table[i].z;
        send_word(dir_table[i].cmd, v, dir_table[i].fixed,
                  '{dir_table[i].fix_same, dir_table[i].fix_status});
      end
    end
    send_word(CMD_COMPARE, rand_vertex(), 1'b0, '0);

    // random polygon pairs, one tolerance per phase
    for (phase = 0; phase < N_PHASES; phase++) begin
      set_epsilon(eps_plan[phase]);
      calm_mode = (phase == 2);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (phase == 0 && !hold_done && items_sent + PHASE_ITEMS / 2 > phase_end) begin
          rx_hold_req = 1'b1;
          hold_done   = 1'b1;
        end
        run_polygon_case();
      end
      calm_mode = 1'b0;
    end

    // drain and report
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("polygon_same_geometry_compare verification clean");
    else
      $display("polygon_same_geometry_compare verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/psgc_pkg.sv
rtl/core/psgc_if.sv
rtl/core/psgc_ram.sv
rtl/core/psgc_vmatch.sv
rtl/core/polygon_same_geometry_compare.sv
dv/testbench.sv
